// ===== design/msg_pkg.sv =====
// Package for the multivector sigmoid gate: widths, codes, sigmoid breakpoints and shared types.
// No dependencies. Every other file of the block imports it.
`timescale 1ns / 1ps

package msg_pkg;

    localparam int DATA_W    = 16;
    localparam int ACC_W     = 40;
    localparam int GATE_W    = 16;
    localparam int INV_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int SEGMENTS  = 16;
    localparam int SEG_IDX_W = $clog2(SEGMENTS);

    // Shared multiplier operand widths: A holds the upper part of a 40-bit magnitude.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [1:0] MODE_DOT  = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;
    localparam logic [1:0] MODE_MEAN = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_INV  = 1'b1;

    localparam logic [INV_W-1:0]  INV_RESET  = 16'hFFFF;
    localparam logic [GATE_W-1:0] GATE_RESET = 16'h8000;

    // Sigmoid input range is [-8, 8) in units of 2^-16.
    localparam logic signed [ACC_W-1:0] SIG_LIMIT = 40'sd524288;

    // Breakpoint gate values at x = -8, -7, ..., 8, unsigned Q0.16.
    localparam logic [GATE_W-1:0] SIG_TABLE [0:SEGMENTS] = '{
        16'd22,    16'd60,    16'd162,   16'd439,   16'd1179,  16'd3108,
        16'd7812,  16'd17625, 16'd32768, 16'd47911, 16'd57724, 16'd62428,
        16'd64357, 16'd65097, 16'd65374, 16'd65476, 16'd65514
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FULL_MUL,
        ST_FULL_WB,
        ST_PK_MUL,
        ST_PK_ACC,
        ST_BIAS_MUL,
        ST_BIAS_ACC,
        ST_MEAN_HI,
        ST_MEAN_LO,
        ST_MEAN_SUM,
        ST_SIG_SEG,
        ST_SIG_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]       mode;
        logic [INV_W-1:0] inverse_count;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] product;
        logic [GATE_W-1:0]        gate;
        logic                     row_end;
    } t_result;

endpackage

// ===== design/msg_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on msg_pkg for the operand widths.
`timescale 1ns / 1ps

module msg_mul
    import msg_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== design/msg_cfg.sv =====
// APB register file holding reduce_mode and inverse_count.
// Depends on msg_pkg for register indexes, widths and the configuration struct.
`timescale 1ns / 1ps

module msg_cfg
    import msg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_MODE: n_cfg.mode          = pwdata[1:0];
                REG_INV:  n_cfg.inverse_count = pwdata[INV_W-1:0];
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_DOT;
            r_cfg.inverse_count <= INV_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, r_cfg.mode};
            REG_INV:  prdata = {{(APB_DATA_W-INV_W){1'b0}}, r_cfg.inverse_count};
            default:  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/msg_core.sv =====
// Sequencer and datapath: reduction, mean scaling, sigmoid interpolation and gating,
// all through one shared multiplier. Depends on msg_pkg and msg_mul.
`timescale 1ns / 1ps

module msg_core
    import msg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_start,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_bias,
    input  logic                     i_last,
    input  logic                     i_out_free,
    output logic                     o_busy,
    output logic                     o_res_load,
    output t_result                  o_result
);

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_sample, r_weight, r_bias;
    logic                     r_last;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]         r_hi, n_hi;
    logic [GATE_W-1:0]        r_gate, n_gate;
    logic [GATE_W-1:0]        r_base, n_base;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [ACC_W:0]    sum_ext;
    logic signed [ACC_W-1:0]  sat_sum;
    logic [ACC_W-1:0]         acc_abs;
    logic [ACC_W-1:0]         mean_mag;
    logic signed [ACC_W-1:0]  mean_res;
    logic [ACC_W-1:0]         x_off;
    logic [SEG_IDX_W:0]       seg_ix;
    logic [FRAC_W-1:0]        frac;
    logic [GATE_W-1:0]        v_lo, v_hi;
    logic signed [GATE_W:0]   v_diff;
    logic                     lo_clamp, hi_clamp;
    logic signed [33:0]       full_round;
    logic signed [17:0]       full_q;
    logic signed [DATA_W-1:0] full_sat;
    logic                     res_load;
    logic                     mode_dot;
    logic                     mode_mean;

    msg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign mode_dot  = (i_cfg.mode == MODE_DOT);
    assign mode_mean = (i_cfg.mode == MODE_MEAN);

    // Saturating accumulate of the registered product; products stay within 32 bits.
    assign sum_ext = {r_acc[ACC_W-1], r_acc} + mul_p[ACC_W:0];
    always_comb begin
        if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
            sat_sum = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_sum = sum_ext[ACC_W-1:0];
        end
    end

    // Mean scaling works on the magnitude, so it rounds toward zero.
    assign acc_abs  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
    assign mean_mag = r_hi + {{(ACC_W-16){1'b0}}, mul_p[31:16]};
    assign mean_res = r_acc[ACC_W-1] ? -$signed(mean_mag) : $signed(mean_mag);

    // Segment lookup: offset by 8.0 so the segment index is a plain bit field.
    assign lo_clamp = (r_acc <= -SIG_LIMIT);
    assign hi_clamp = (r_acc >= SIG_LIMIT);
    assign x_off    = r_acc + SIG_LIMIT;
    assign seg_ix   = {1'b0, x_off[FRAC_W +: SEG_IDX_W]};
    assign frac     = x_off[FRAC_W-1:0];
    assign v_lo     = SIG_TABLE[seg_ix];
    assign v_hi     = SIG_TABLE[seg_ix + 1'b1];
    assign v_diff   = $signed({1'b0, v_hi}) - $signed({1'b0, v_lo});

    // Gating: round half up, then saturate to Q8.8.
    assign full_round = $signed(mul_p[33:0]) + 34'sd32768;
    assign full_q     = full_round[33:16];
    always_comb begin
        if (full_q > 18'sd32767) begin
            full_sat = 16'sh7FFF;
        end else if (full_q < -18'sd32768) begin
            full_sat = 16'sh8000;
        end else begin
            full_sat = full_q[DATA_W-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_FULL_MUL, ST_FULL_WB: begin
                mul_a = {{(MUL_A_W-DATA_W){r_sample[DATA_W-1]}}, r_sample};
                mul_b = {{(MUL_B_W-GATE_W){1'b0}}, r_gate};
            end
            ST_PK_MUL: begin
                mul_a = {{(MUL_A_W-DATA_W){r_sample[DATA_W-1]}}, r_sample};
                mul_b = mode_dot ? {{(MUL_B_W-DATA_W){r_weight[DATA_W-1]}}, r_weight}
                                 : MUL_B_W'(256);
            end
            ST_BIAS_MUL: begin
                mul_a = {{(MUL_A_W-DATA_W){r_bias[DATA_W-1]}}, r_bias};
                mul_b = MUL_B_W'(256);
            end
            ST_MEAN_HI: begin
                mul_a = {1'b0, acc_abs[ACC_W-1:16]};
                mul_b = {{(MUL_B_W-INV_W){1'b0}}, i_cfg.inverse_count};
            end
            ST_MEAN_LO: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, acc_abs[15:0]};
                mul_b = {{(MUL_B_W-INV_W){1'b0}}, i_cfg.inverse_count};
            end
            ST_SIG_SEG: begin
                mul_a = {{(MUL_A_W-GATE_W-1){v_diff[GATE_W]}}, v_diff};
                mul_b = {{(MUL_B_W-FRAC_W){1'b0}}, frac};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_hi     = r_hi;
        n_gate   = r_gate;
        n_base   = r_base;
        res_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_operation ? ST_FULL_MUL : ST_PK_MUL;
                end
            end
            ST_FULL_MUL: n_state = ST_FULL_WB;
            ST_FULL_WB: begin
                if (i_out_free) begin
                    res_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_PK_MUL: n_state = ST_PK_ACC;
            ST_PK_ACC: begin
                n_acc = sat_sum;
                priority if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (mode_dot) begin
                    n_state = ST_BIAS_MUL;
                end else if (mode_mean) begin
                    n_state = ST_MEAN_HI;
                end else begin
                    n_state = ST_SIG_SEG;
                end
            end
            ST_BIAS_MUL: n_state = ST_BIAS_ACC;
            ST_BIAS_ACC: begin
                n_acc   = sat_sum;
                n_state = ST_SIG_SEG;
            end
            ST_MEAN_HI: n_state = ST_MEAN_LO;
            ST_MEAN_LO: begin
                n_hi    = mul_p[ACC_W-1:0];
                n_state = ST_MEAN_SUM;
            end
            ST_MEAN_SUM: begin
                n_acc   = mean_res;
                n_state = ST_SIG_SEG;
            end
            ST_SIG_SEG: begin
                priority if (lo_clamp) begin
                    n_gate  = SIG_TABLE[0];
                    n_acc   = '0;
                    n_state = ST_IDLE;
                end else if (hi_clamp) begin
                    n_gate  = SIG_TABLE[SEGMENTS];
                    n_acc   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_base  = v_lo;
                    n_state = ST_SIG_FIN;
                end
            end
            ST_SIG_FIN: begin
                n_gate  = r_base + mul_p[FRAC_W +: GATE_W];
                n_acc   = '0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_gate  <= GATE_RESET;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_gate  <= n_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == ST_IDLE)) begin
            r_sample <= i_sample;
            r_weight <= i_weight;
            r_bias   <= i_bias;
            r_last   <= i_last;
        end
        r_hi   <= n_hi;
        r_base <= n_base;
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_res_load       = res_load;
    assign o_result.product = full_sat;
    assign o_result.gate    = r_gate;
    assign o_result.row_end = r_last;

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIG_FIN) |=> (r_acc == '0))
        else $error("accumulator not cleared after the sigmoid step");

    a_gate_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_SIG_SEG) && (r_state != ST_SIG_FIN)) |=> $stable(r_gate))
        else $error("held gate changed outside the sigmoid steps");

    a_result_from_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (($past(r_state) == ST_FULL_MUL) || ($past(r_state) == ST_FULL_WB)))
        else $error("result produced without a full blade multiply");

endmodule

// ===== design/multivector_sigmoid_gate.sv =====
// Top level of the multivector sigmoid gate: register file, sequenced core, output register.
// Depends on msg_pkg, msg_cfg, msg_core (which holds msg_mul).
`timescale 1ns / 1ps

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+---------------------------------------------
// input    | in        | i_valid, o_stall  | i_operation, i_sample, i_weight, i_bias, i_last
// output   | out       | o_valid, i_stall  | o_product, o_gate, o_row_end
// config   | in/out    | psel, penable,    | paddr, pwdata, prdata
//          |           | pwrite, pready    |
//
// One item is in flight at a time; o_stall is high from the cycle after a transfer until
// the item is done. A full blade passes accept, multiply and writeback, and stays in
// writeback while the output register is blocked. A packed blade passes accept, multiply
// and accumulate; a row's last one adds the bias steps in dot mode or the mean steps in
// mean mode, then sigmoid segment and finish (segment alone at or beyond -8 or 8). Each
// step is one pass through the single shared multiplier, whose product is registered.
// Reset is synchronous and active low; it clears the accumulator, sets the held gate to
// one half and the registers to dot mode with inverse_count all ones.
// The output register lets a new item be accepted while a finished result waits on i_stall.

module multivector_sigmoid_gate
    import msg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_bias,
    input  logic                     i_last,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_product,
    output logic [GATE_W-1:0]        o_gate,
    output logic                     o_row_end,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready
);

    t_cfg    cfg;
    t_result core_result;
    logic    core_busy;
    logic    core_load;
    logic    out_free;
    logic    in_xfer;

    logic    r_o_valid;
    t_result r_out;

    // The register file applies writes in the access phase of each APB transfer.
    msg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The output register can take a new result when it is empty or being drained now.
    assign out_free = !r_o_valid || !i_stall;
    assign in_xfer  = i_valid && !core_busy;

    msg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (in_xfer),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_weight    (i_weight),
        .i_bias      (i_bias),
        .i_last      (i_last),
        .i_out_free  (out_free),
        .o_busy      (core_busy),
        .o_res_load  (core_load),
        .o_result    (core_result)
    );

    // Output register: valid is cleared on a completed transfer unless a new result lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (core_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_load) begin
            r_out <= core_result;
        end
    end

    assign o_stall   = core_busy;
    assign o_valid   = r_o_valid;
    assign o_product = r_out.product;
    assign o_gate    = r_out.gate;
    assign o_row_end = r_out.row_end;

endmodule

// ===== dv/tb_multivector_sigmoid_gate.sv =====
// Self-checking testbench for multivector_sigmoid_gate: blade transfers and APB register
// writes go in, and each gated result is checked against a predictor of its own.
// Depends on msg_pkg and the design files of the block.
`timescale 1ns / 1ps

module tb_multivector_sigmoid_gate;
    import msg_pkg::*;

    // Item operations and the reduce mode that the package leaves unnamed.
    localparam logic       OP_PACKED  = 1'b0;
    localparam logic       OP_FULL    = 1'b1;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int PERIOD       = 10;
    localparam int PWL_SEGMENTS = 16;
    localparam int SETTLE       = 24;       // outlasts the longest packed item
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ROW_ITEMS    = 80;       // fewest blade transfers queued per random phase
    localparam int LONG_ROW     = 520;      // enough maximal products to saturate the sum

    localparam logic [GATE_W-1:0] GATE_AT_RESET = 16'h8000;
    localparam logic [INV_W-1:0]  INV_AT_RESET  = 16'hFFFF;

    typedef longint unsigned t_u64;

    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -ACC_HI - 1;
    localparam longint SIG_EDGE = longint'(8) <<< FRAC_W;    // 8.0 in units of 2^-16
    localparam longint SIG_SPAN = 2 * SIG_EDGE;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] bias;
        logic                     last;
    } t_blade;

    // Every input is known from time zero.
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     i_operation = 1'b0;
    logic signed [DATA_W-1:0] i_sample    = '0;
    logic signed [DATA_W-1:0] i_weight    = '0;
    logic signed [DATA_W-1:0] i_bias      = '0;
    logic                     i_last      = 1'b0;
    logic                     i_stall     = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr       = '0;
    logic [APB_DATA_W-1:0]    pwdata      = '0;

    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_product;
    logic [GATE_W-1:0]        o_gate;
    logic                     o_row_end;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    multivector_sigmoid_gate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_weight    (i_weight),
        .i_bias      (i_bias),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_product   (o_product),
        .o_gate      (o_gate),
        .o_row_end   (o_row_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // Blades waiting to be driven, and gated results that the predictor says are due.
    t_blade  blade_queue [$];
    t_result gated_due [$];
    t_blade  blade_out;

    // Predictor copy of the registers and of the row state.
    logic [1:0]        mode_now  = MODE_DOT;
    logic [INV_W-1:0]  inv_now   = INV_AT_RESET;
    longint            row_acc   = 0;
    logic [GATE_W-1:0] gate_held = GATE_AT_RESET;

    bit in_taken     = 1'b0;
    bit steady       = 1'b0;   // while set, neither side idles
    int queued_count = 0;
    int taken_count  = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int failures     = 0;
    int cycles       = 0;

    // Saturating add at the accumulator width.
    function automatic longint acc_add(input longint a, input longint t);
        if (t > 0 && a > ACC_HI - t) return ACC_HI;
        if (t < 0 && a < ACC_LO - t) return ACC_LO;
        return a + t;
    endfunction

    // Sigmoid value at one breakpoint, Q0.16. The exponential is a fourth-order series of
    // e^-(x/64) raised to the 64th power by six squarings, all in 32-bit fixed point.
    function automatic int knot_gate(input longint x);
        t_u64 mag, d, d2, d3, d4, y, den, v;
        mag = (x < 0) ? t_u64'(-x) : t_u64'(x);
        if (mag == 0) return 32768;
        d  = mag << 10;
        d2 = (d * d) >> 32;
        d3 = (d2 * d) >> 32;
        d4 = (d3 * d) >> 32;
        y  = (t_u64'(1) << 32) - d + d2 / 2 - d3 / 6 + d4 / 24;
        for (int k = 0; k < 6; k++) y = (y * y) >> 32;
        den = (t_u64'(1) << 32) + y;
        v   = ((t_u64'(1) << 48) + den / 2) / den;
        if (v > 65535) v = 65535;
        return (x < 0) ? int'(65536 - v) : int'(v);
    endfunction

    // Piecewise-linear sigmoid of a sum scaled by 2^-16, flat beyond [-8, 8].
    function automatic logic [GATE_W-1:0] pwl_gate(input longint x);
        longint seg, xi, xj, vi, vj, g;
        if (x <= -SIG_EDGE) return GATE_W'(knot_gate(-SIG_EDGE));
        if (x >= SIG_EDGE) return GATE_W'(knot_gate(SIG_EDGE));
        seg = ((x + SIG_EDGE) * PWL_SEGMENTS) / SIG_SPAN;
        if (seg > PWL_SEGMENTS - 1) seg = PWL_SEGMENTS - 1;
        xi = -SIG_EDGE + (seg * SIG_SPAN) / PWL_SEGMENTS;
        xj = -SIG_EDGE + ((seg + 1) * SIG_SPAN) / PWL_SEGMENTS;
        vi = knot_gate(xi);
        vj = knot_gate(xj);
        // Signed division truncates toward zero, as the interpolation requires.
        g = vi + ((vj - vi) * (x - xi)) / (xj - xi);
        if (g < 0) g = 0;
        if (g > 65535) g = 65535;
        return g[GATE_W-1:0];
    endfunction

    // Advance the row state by one accepted blade; a full blade leaves one result due.
    task automatic advance_gate_row(input t_blade b);
        longint  sum;
        longint  prod;
        t_u64    mag;
        t_u64    scaled;
        t_result res;
        if (b.op == OP_FULL) begin
            // Round half up, then saturate to Q8.8.
            prod = (longint'(b.sample) * longint'(gate_held) + 32768) >>> FRAC_W;
            if (prod > 32767) prod = 32767;
            if (prod < -32768) prod = -32768;
            res.product = prod[DATA_W-1:0];
            res.gate    = gate_held;
            res.row_end = b.last;
            gated_due.push_back(res);
        end else begin
            // The spare mode code behaves as a plain sum.
            if (mode_now == MODE_DOT) begin
                row_acc = acc_add(row_acc, longint'(b.sample) * longint'(b.weight));
            end else begin
                row_acc = acc_add(row_acc, longint'(b.sample) * 256);
            end
            if (b.last) begin
                if (mode_now == MODE_DOT) row_acc = acc_add(row_acc, longint'(b.bias) * 256);
                sum = row_acc;
                if (mode_now == MODE_MEAN) begin
                    // Scale the magnitude so that the mean rounds toward zero.
                    mag    = (sum < 0) ? t_u64'(-sum) : t_u64'(sum);
                    scaled = (mag >> 16) * inv_now + (((mag & 64'hFFFF) * inv_now) >> 16);
                    sum    = (sum < 0) ? -longint'(scaled) : longint'(scaled);
                end
                gate_held = pwl_gate(sum);
                row_acc   = 0;
            end
        end
    endtask

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 21);
    endfunction

    // Uniform value in [-span, span], or any 16-bit pattern for the full span.
    function automatic logic signed [DATA_W-1:0] draw_val(input int span);
        if (span >= 32768) return DATA_W'($urandom);
        return DATA_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Magnitude class for a row: small classes keep the sum inside the sigmoid's slope,
    // the large ones push it onto the flat ends.
    function automatic int pick_span();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return 64;
        if (r < 55) return 600;
        if (r < 80) return 4000;
        return 32768;
    endfunction

    // Sampling at the rising edge: record input transfers, check output transfers.
    always @(posedge i_clk) begin : monitor
        t_result want;
        cycles++;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            advance_gate_row(blade_out);
            taken_count++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (gated_due.size() == 0) begin
                failures++;
                $display("%0t: result with nothing due: product %0d gate %0d row_end %0b",
                         $time, o_product, o_gate, o_row_end);
            end else begin
                want = gated_due.pop_front();
                results_seen++;
                if (o_product !== want.product) begin
                    failures++;
                    $display("%0t: product expected %0d, actual %0d",
                             $time, want.product, o_product);
                end
                if (o_gate !== want.gate) begin
                    failures++;
                    $display("%0t: gate expected %0d, actual %0d", $time, want.gate, o_gate);
                end
                if (o_row_end !== want.row_end) begin
                    failures++;
                    $display("%0t: row_end expected %0b, actual %0b",
                             $time, want.row_end, o_row_end);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, gated_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Driver: at the falling edge, either hold a stalled transfer, present the next blade,
    // or idle. The output side stalls at random, independent of the input side.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (blade_queue.size() != 0 && !take_break()) begin
                blade_out = blade_queue.pop_front();
                i_operation <= blade_out.op;
                i_sample    <= blade_out.sample;
                i_weight    <= blade_out.weight;
                i_bias      <= blade_out.bias;
                i_last      <= blade_out.last;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= take_break();
    end

    task automatic queue_blade(input logic op, input logic signed [DATA_W-1:0] sample,
                               input logic signed [DATA_W-1:0] weight,
                               input logic signed [DATA_W-1:0] bias, input logic last);
        t_blade b;
        b.op     = op;
        b.sample = sample;
        b.weight = weight;
        b.bias   = bias;
        b.last   = last;
        blade_queue.push_back(b);
        queued_count++;
    endtask

    // Wait until every blade is taken and every result is in. Packed blades leave no
    // result, so the block may still be reducing; wait out the settle time as well.
    task automatic drain();
        while (taken_count != queued_count || gated_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // APB write of one register, then a read back of the value just written.
    task automatic set_register(input logic index, input logic [15:0] value);
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        if (index == REG_MODE) begin
            mode_now = value[1:0];
        end else begin
            inv_now = value;
        end
        reg_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        want = (index == REG_MODE) ? {30'd0, mode_now} : {16'd0, inv_now};
        if (prdata !== want) begin
            failures++;
            $display("%0t: register %0d read expected %0d, actual %0d",
                     $time, index, want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random rows until the target count is queued. Most rows are well formed: a run of
    // packed blades closed by last, then full blades closed by last. The rest are open
    // packed runs that later rows continue, and loose blades with random operation and last.
    task automatic queue_rows(input int target);
        int          added;
        int unsigned kind;
        int          packs;
        int          fulls;
        int          span_s;
        int          span_w;
        int          span_b;
        added = 0;
        while (added < target) begin
            kind   = $urandom_range(99);
            span_s = pick_span();
            span_w = pick_span();
            span_b = pick_span();
            packs  = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
            fulls  = $urandom_range(5, 1);
            if (kind < 80) begin
                for (int k = 0; k < packs; k++) begin
                    queue_blade(OP_PACKED, draw_val(span_s), draw_val(span_w),
                                draw_val(span_b), k == packs - 1);
                end
                for (int k = 0; k < fulls; k++) begin
                    queue_blade(OP_FULL, draw_val(32768), draw_val(32768), draw_val(32768),
                                k == fulls - 1);
                end
                added += packs + fulls;
            end else if (kind < 88) begin
                for (int k = 0; k < packs; k++) begin
                    queue_blade(OP_PACKED, draw_val(span_s), draw_val(span_w),
                                draw_val(span_b), 1'b0);
                end
                added += packs;
            end else begin
                for (int k = 0; k < fulls; k++) begin
                    queue_blade($urandom_range(1), draw_val(span_s), draw_val(32768),
                                draw_val(32768), $urandom_range(1));
                end
                added += fulls;
            end
        end
    endtask

    // One register setting with random traffic. Half the phases end inside a packed run,
    // so the next phase finishes that row under its own register setting.
    task automatic run_phase(input logic [1:0] mode, input logic [15:0] inv, input bit calm);
        set_register(REG_MODE, {14'd0, mode});
        set_register(REG_INV, inv);
        steady = calm;
        queue_rows(ROW_ITEMS);
        if ($urandom_range(1)) begin
            for (int k = 0; k < 3; k++) begin
                queue_blade(OP_PACKED, draw_val(600), draw_val(600), draw_val(600), 1'b0);
            end
        end
        drain();
        steady = 1'b0;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset registers (dot product mode).
        // Full blades before any reduction use the gate of one half.
        queue_blade(OP_FULL, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
        queue_blade(OP_FULL, -16'sh8000, 16'sh7FFF, -16'sh8000, 1'b1);
        // Extreme products and bias drive the sum far above the sigmoid range.
        queue_blade(OP_PACKED, -16'sh8000, -16'sh8000, 16'sh0000, 1'b0);
        queue_blade(OP_PACKED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        queue_blade(OP_FULL, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
        queue_blade(OP_FULL, -16'sh8000, 16'sh0000, 16'sh0000, 1'b0);
        // Weight, bias and last bits all ones play no part in a product.
        queue_blade(OP_FULL, 16'sh0000, -16'sh0001, -16'sh0001, 1'b1);
        // A sum of exactly 1.0 lands on a breakpoint.
        queue_blade(OP_PACKED, 16'sh0100, 16'sh0100, 16'sh0000, 1'b1);
        queue_blade(OP_FULL, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1);
        // Far below the range.
        queue_blade(OP_PACKED, -16'sh8000, 16'sh7FFF, -16'sh8000, 1'b1);
        queue_blade(OP_FULL, -16'sh8000, 16'sh0000, 16'sh0000, 1'b1);
        // Interpolated inside a segment, with the bias adding on the last item.
        queue_blade(OP_PACKED, 16'sh0080, 16'sh0100, 16'sh7FFF, 1'b0);
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, 16'sh0040, 1'b1);
        queue_blade(OP_FULL, 16'sh0001, 16'sh0000, 16'sh0000, 1'b1);
        // Smallest negative sum, just left of zero.
        queue_blade(OP_PACKED, -16'sh0001, 16'sh0001, 16'sh0000, 1'b1);
        queue_blade(OP_FULL, -16'sh0001, 16'sh0000, 16'sh0000, 1'b1);
        // Exactly at the upper and lower ends, then one step inside the lower end.
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, 16'sh0800, 1'b1);
        queue_blade(OP_FULL, 16'sh3039, 16'sh0000, 16'sh0000, 1'b1);
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, -16'sh0800, 1'b1);
        queue_blade(OP_FULL, -16'sh3039, 16'sh0000, 16'sh0000, 1'b0);
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, -16'sh07FF, 1'b1);
        queue_blade(OP_FULL, 16'sh4000, 16'sh0000, 16'sh0000, 1'b1);
        drain();

        // Random phases across all reduce modes and the extremes of inverse_count.
        run_phase(MODE_DOT, 16'($urandom), 1'b0);
        run_phase(MODE_SUM, 16'h0000, 1'b0);
        run_phase(MODE_MEAN, 16'hFFFF, 1'b0);
        run_phase(MODE_MEAN, 16'h0000, 1'b0);
        run_phase(MODE_SPARE, 16'hFFFF, 1'b0);
        run_phase(MODE_MEAN, 16'($urandom_range(65535)), 1'b1);
        run_phase(MODE_DOT, 16'h0000, 1'b0);
        run_phase(MODE_SUM, 16'($urandom), 1'b0);
        run_phase(MODE_MEAN, 16'h0001, 1'b0);

        // Two long dot-product rows that run the accumulator into its positive and then its
        // negative limit; the closing bias then pulls each back off the limit.
        set_register(REG_MODE, {14'd0, MODE_DOT});
        for (int k = 0; k < LONG_ROW; k++) begin
            queue_blade(OP_PACKED, -16'sh8000 + 16'($urandom_range(3)), -16'sh8000,
                        draw_val(32768), 1'b0);
        end
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, -16'sh8000, 1'b1);
        queue_blade(OP_FULL, draw_val(32768), 16'sh0000, 16'sh0000, 1'b1);
        for (int k = 0; k < LONG_ROW; k++) begin
            queue_blade(OP_PACKED, 16'sh7FFF - 16'($urandom_range(3)), -16'sh8000,
                        draw_val(32768), 1'b0);
        end
        queue_blade(OP_PACKED, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b1);
        queue_blade(OP_FULL, draw_val(32768), 16'sh0000, 16'sh0000, 1'b1);
        drain();

        $display("summary: %0d blade transfers in, %0d gated results checked, %0d register writes",
                 taken_count, results_seen, reg_writes);
        $display("summary: reduce modes 0 to 3, inverse_count 0, 1 and all ones, saturated sums");
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
